// ----- src/rdmc_pkg.sv -----
// Shared types and constants for the maze carver block.
// No dependencies; used by rdmc_ctrl, rdmc_dpath and random_dfs_maze_carver.
package rdmc_pkg;

    // Input opcodes (code 3 is unused and only returns a result)
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Field widths fixed by the interface
    localparam int OP_W    = 2;
    localparam int RND_W   = 16;
    localparam int COORD_W = 6;
    localparam int CFG_W   = 7;

    // Width of the epoch tag stored per grid cell
    localparam int TAG_W = 4;

    // Reset value of both extent registers
    localparam logic [CFG_W-1:0] EXTENT_RESET = 7'd10;

    // Probe directions, in probe order
    typedef enum logic [1:0] {
        DIR_YP = 2'd0,  // (0,+2)
        DIR_XP = 2'd1,  // (+2,0)
        DIR_YM = 2'd2,  // (0,-2)
        DIR_XM = 2'd3   // (-2,0)
    } t_dir;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_START,
        S_POP,
        S_LOAD,
        S_PROBE,
        S_DECIDE,
        S_CARVE_A,
        S_CARVE_B,
        S_READ,
        S_READ_CHK,
        S_REPLY
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;      // latch the input item, clear result fields
        logic clr_step;     // write one grid entry of the clearing pass
        logic epoch_bump;   // next epoch for a new maze
        logic epoch_reset;  // epoch back to one before a clearing pass
        logic start_init;   // carve (0,0) and push it
        logic pop;          // pop the top entry, issue its read
        logic load;         // take the popped cell, reset probe state
        logic probe;        // advance the probe pipeline
        logic decide;       // choose among the candidates
        logic carve_a;      // carve neighbor, push current
        logic carve_b;      // carve wall between, push neighbor
        logic rd_issue;     // issue grid read for a query
        logic rd_chk;       // evaluate the query read
        logic reply;        // load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       clr_last;
        logic       epoch_wrap;
        logic       stack_empty;
        logic       probe_last;
        logic       no_cand;
        logic       out_free;
    } t_stat;

endpackage

// ----- src/rdmc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rdmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/rdmc_ctrl.sv -----
// Sequencer of the maze carver: state machine issuing datapath commands.
// Depends on rdmc_pkg.
module rdmc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rdmc_pkg::t_stat i_stat,
    output rdmc_pkg::t_cmd  o_cmd
);

    rdmc_pkg::t_state r_state, n_state;
    logic             r_clr_start, n_clr_start;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdmc_pkg::S_CLEAR;
            r_clr_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_start <= n_clr_start;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_clr_start = r_clr_start;
        unique case (r_state)
            rdmc_pkg::S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state     = r_clr_start ? rdmc_pkg::S_START : rdmc_pkg::S_IDLE;
                    n_clr_start = 1'b0;
                end
            end
            rdmc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rdmc_pkg::S_DISPATCH;
                end
            end
            rdmc_pkg::S_DISPATCH: begin
                unique case (i_stat.op)
                    rdmc_pkg::OP_START: begin
                        if (i_stat.epoch_wrap) begin
                            n_state     = rdmc_pkg::S_CLEAR;
                            n_clr_start = 1'b1;
                        end else begin
                            n_state = rdmc_pkg::S_START;
                        end
                    end
                    rdmc_pkg::OP_STEP: n_state = rdmc_pkg::S_POP;
                    rdmc_pkg::OP_READ: n_state = rdmc_pkg::S_READ;
                    default:           n_state = rdmc_pkg::S_REPLY;
                endcase
            end
            rdmc_pkg::S_START: n_state = rdmc_pkg::S_REPLY;
            rdmc_pkg::S_POP: begin
                n_state = i_stat.stack_empty ? rdmc_pkg::S_REPLY : rdmc_pkg::S_LOAD;
            end
            rdmc_pkg::S_LOAD: n_state = rdmc_pkg::S_PROBE;
            rdmc_pkg::S_PROBE: begin
                if (i_stat.probe_last) begin
                    n_state = rdmc_pkg::S_DECIDE;
                end
            end
            rdmc_pkg::S_DECIDE: begin
                // dead end: backtrack to the next stacked cell
                n_state = i_stat.no_cand ? rdmc_pkg::S_POP : rdmc_pkg::S_CARVE_A;
            end
            rdmc_pkg::S_CARVE_A:  n_state = rdmc_pkg::S_CARVE_B;
            rdmc_pkg::S_CARVE_B:  n_state = rdmc_pkg::S_REPLY;
            rdmc_pkg::S_READ:     n_state = rdmc_pkg::S_READ_CHK;
            rdmc_pkg::S_READ_CHK: n_state = rdmc_pkg::S_REPLY;
            rdmc_pkg::S_REPLY: begin
                if (i_stat.out_free) begin
                    n_state = rdmc_pkg::S_IDLE;
                end
            end
            default: n_state = rdmc_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rdmc_pkg::S_CLEAR: o_cmd.clr_step = 1'b1;
            rdmc_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            rdmc_pkg::S_DISPATCH: begin
                if (i_stat.op == rdmc_pkg::OP_START) begin
                    o_cmd.epoch_reset = i_stat.epoch_wrap;
                    o_cmd.epoch_bump  = !i_stat.epoch_wrap;
                end
            end
            rdmc_pkg::S_START: o_cmd.start_init = 1'b1;
            rdmc_pkg::S_POP:   o_cmd.pop = !i_stat.stack_empty;
            rdmc_pkg::S_LOAD:  o_cmd.load = 1'b1;
            rdmc_pkg::S_PROBE: o_cmd.probe = 1'b1;
            rdmc_pkg::S_DECIDE: o_cmd.decide = !i_stat.no_cand;
            rdmc_pkg::S_CARVE_A: o_cmd.carve_a = 1'b1;
            rdmc_pkg::S_CARVE_B: o_cmd.carve_b = 1'b1;
            rdmc_pkg::S_READ:     o_cmd.rd_issue = 1'b1;
            rdmc_pkg::S_READ_CHK: o_cmd.rd_chk = 1'b1;
            rdmc_pkg::S_REPLY:    o_cmd.reply = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- src/rdmc_dpath.sv -----
// Datapath of the maze carver: extents, grid and stack memories, probe logic,
// output register. Depends on rdmc_pkg and rdmc_ram.
module rdmc_dpath #(
    parameter int MAX_DIM     = 64,
    parameter int STACK_DEPTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [rdmc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [rdmc_pkg::OP_W-1:0]      i_opcode,
    input  logic [rdmc_pkg::RND_W-1:0]     i_random_word,
    input  logic [rdmc_pkg::COORD_W-1:0]   i_query_x,
    input  logic [rdmc_pkg::COORD_W-1:0]   i_query_y,
    input  rdmc_pkg::t_cmd                 i_cmd,
    output rdmc_pkg::t_stat                o_stat,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [rdmc_pkg::COORD_W-1:0]   o_carved_x,
    output logic [rdmc_pkg::COORD_W-1:0]   o_carved_y,
    output logic                           o_carved_valid,
    output logic                           o_finished,
    output logic                           o_wall_bit
);

    localparam int AW    = $clog2(MAX_DIM);            // coordinate bits
    localparam int GAW   = 2 * AW;                     // grid address bits
    localparam int GDEP  = 1 << GAW;
    localparam int CW    = (AW + 3 > 8) ? AW + 3 : 8;  // compare width
    localparam int DW    = $clog2(STACK_DEPTH + 1);    // depth counter bits
    localparam int SAW   = $clog2(STACK_DEPTH);        // stack address bits
    localparam int TW    = rdmc_pkg::TAG_W;

    // ---------------------------------------------------------------
    // helpers
    // ---------------------------------------------------------------
    function automatic logic [CW-1:0] extent(input logic [rdmc_pkg::CFG_W-1:0] v);
        logic [CW-1:0] vv;
        vv = CW'(v);
        if (vv == '0) begin
            extent = CW'(1);
        end else if (vv > CW'(MAX_DIM)) begin
            extent = CW'(MAX_DIM);
        end else begin
            extent = vv;
        end
    endfunction

    // neighbor two cells away (or one when half is set), in compare width
    function automatic logic [CW-1:0] step_x(input rdmc_pkg::t_dir d,
                                             input logic [AW-1:0] x,
                                             input logic half);
        logic [CW-1:0] s;
        s = half ? CW'(1) : CW'(2);
        case (d)
            rdmc_pkg::DIR_XP: step_x = CW'(x) + s;
            rdmc_pkg::DIR_XM: step_x = CW'(x) - s;
            default:          step_x = CW'(x);
        endcase
    endfunction

    function automatic logic [CW-1:0] step_y(input rdmc_pkg::t_dir d,
                                             input logic [AW-1:0] y,
                                             input logic half);
        logic [CW-1:0] s;
        s = half ? CW'(1) : CW'(2);
        case (d)
            rdmc_pkg::DIR_YP: step_y = CW'(y) + s;
            rdmc_pkg::DIR_YM: step_y = CW'(y) - s;
            default:          step_y = CW'(y);
        endcase
    endfunction

    // value mod 3 by summing base-4 digits (4 = 1 mod 3)
    function automatic logic [1:0] mod3(input logic [rdmc_pkg::RND_W-1:0] v);
        logic [4:0] s1;
        logic [2:0] s2;
        s1 = '0;
        for (int i = 0; i < rdmc_pkg::RND_W / 2; i++) begin
            s1 = s1 + 5'(v[2*i +: 2]);
        end
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        case (s2)
            3'd0, 3'd3, 3'd6: mod3 = 2'd0;
            3'd1, 3'd4, 3'd7: mod3 = 2'd1;
            default:          mod3 = 2'd2;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [rdmc_pkg::CFG_W-1:0] r_width, r_height;
    logic [CW-1:0]              w_ext, h_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rdmc_pkg::EXTENT_RESET;
            r_height <= rdmc_pkg::EXTENT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rdmc_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                default:              r_height <= i_cfg_data;
            endcase
        end
    end

    assign w_ext = extent(r_width);
    assign h_ext = extent(r_height);

    // ---------------------------------------------------------------
    // state and item registers
    // ---------------------------------------------------------------
    logic [TW-1:0]                r_epoch;
    logic [GAW-1:0]               r_clr_addr;
    logic [DW-1:0]                r_depth;
    logic [rdmc_pkg::OP_W-1:0]    r_op;
    logic [rdmc_pkg::RND_W-1:0]   r_rnd;
    logic [1:0]                   r_mod3;
    logic [rdmc_pkg::COORD_W-1:0] r_qx, r_qy;
    logic [AW-1:0]                r_cur_x, r_cur_y;
    logic [2:0]                   r_k;
    logic                         r_chk, r_chk_inb;
    rdmc_pkg::t_dir               r_chk_dir;
    logic [2:0]                   r_cnt;
    rdmc_pkg::t_dir               r_dirs [4];
    rdmc_pkg::t_dir               r_sel_dir;
    logic                         r_rd_inb;
    logic [rdmc_pkg::COORD_W-1:0] r_res_x, r_res_y;
    logic                         r_res_valid, r_res_wall;
    logic                         r_out_valid;
    logic [rdmc_pkg::COORD_W-1:0] r_out_x, r_out_y;
    logic                         r_out_cv, r_out_fin, r_out_wall;

    // memory ports
    logic              g_we;
    logic [GAW-1:0]    g_waddr, g_raddr;
    logic [TW-1:0]     g_wdata, g_rdata;
    logic              s_we;
    logic [SAW-1:0]    s_waddr, s_raddr;
    logic [GAW-1:0]    s_wdata, s_rdata;

    // ---------------------------------------------------------------
    // neighbor arithmetic
    // ---------------------------------------------------------------
    rdmc_pkg::t_dir    probe_dir;
    logic [CW-1:0]     pr_x, pr_y, sel_x, sel_y, mid_x, mid_y;
    logic              pr_inb, q_inb, can_push, cand_hit;
    logic [1:0]        pick;
    logic [DW-1:0]     depth_m1;

    assign probe_dir = rdmc_pkg::t_dir'(r_k[1:0]);
    assign pr_x  = step_x(probe_dir, r_cur_x, 1'b0);
    assign pr_y  = step_y(probe_dir, r_cur_y, 1'b0);
    assign sel_x = step_x(r_sel_dir, r_cur_x, 1'b0);
    assign sel_y = step_y(r_sel_dir, r_cur_y, 1'b0);
    assign mid_x = step_x(r_sel_dir, r_cur_x, 1'b1);
    assign mid_y = step_y(r_sel_dir, r_cur_y, 1'b1);

    // negative targets are caught before the unsigned extent compare
    assign pr_inb = !(probe_dir == rdmc_pkg::DIR_YM && r_cur_y < AW'(2))
                 && !(probe_dir == rdmc_pkg::DIR_XM && r_cur_x < AW'(2))
                 && (pr_x < w_ext) && (pr_y < h_ext);

    assign q_inb    = (CW'(r_qx) < w_ext) && (CW'(r_qy) < h_ext);
    assign can_push = r_depth < DW'(STACK_DEPTH);
    assign depth_m1 = r_depth - DW'(1);
    assign cand_hit = r_chk && r_chk_inb && (g_rdata != r_epoch);

    // candidate number random modulo count
    always_comb begin
        case (r_cnt)
            3'd2:    pick = {1'b0, r_rnd[0]};
            3'd3:    pick = r_mod3;
            3'd4:    pick = r_rnd[1:0];
            default: pick = 2'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // grid memory port selection
    // ---------------------------------------------------------------
    always_comb begin
        g_we    = 1'b0;
        g_waddr = '0;
        g_wdata = r_epoch;
        g_raddr = '0;
        if (i_cmd.clr_step) begin
            g_we    = 1'b1;
            g_waddr = r_clr_addr;
            g_wdata = '0;
        end
        if (i_cmd.start_init) begin
            g_we = 1'b1;
        end
        if (i_cmd.carve_a) begin
            g_we    = 1'b1;
            g_waddr = {sel_x[AW-1:0], sel_y[AW-1:0]};
        end
        if (i_cmd.carve_b) begin
            g_we    = 1'b1;
            g_waddr = {mid_x[AW-1:0], mid_y[AW-1:0]};
        end
        if (i_cmd.probe && !r_k[2]) begin
            g_raddr = {pr_x[AW-1:0], pr_y[AW-1:0]};
        end
        if (i_cmd.rd_issue) begin
            g_raddr = {AW'(r_qx), AW'(r_qy)};
        end
    end

    // ---------------------------------------------------------------
    // stack memory port selection
    // ---------------------------------------------------------------
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_depth[SAW-1:0];
        s_wdata = {r_cur_x, r_cur_y};
        s_raddr = depth_m1[SAW-1:0];
        if (i_cmd.start_init) begin
            s_we    = 1'b1;
            s_waddr = '0;
            s_wdata = '0;
        end
        if (i_cmd.carve_a) begin
            s_we = can_push;
        end
        if (i_cmd.carve_b) begin
            s_we    = can_push;
            s_wdata = {sel_x[AW-1:0], sel_y[AW-1:0]};
        end
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch     <= TW'(1);
            r_clr_addr  <= '0;
            r_depth     <= '0;
            r_k         <= '0;
            r_chk       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // epoch: new maze makes every stored tag stale
            if (i_cmd.epoch_reset) begin
                r_epoch <= TW'(1);
            end else if (i_cmd.epoch_bump) begin
                r_epoch <= r_epoch + TW'(1);
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + GAW'(1);
            end
            // stack depth
            if (i_cmd.start_init) begin
                r_depth <= DW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= depth_m1;
            end else if ((i_cmd.carve_a || i_cmd.carve_b) && can_push) begin
                r_depth <= r_depth + DW'(1);
            end
            // probe pipeline: issue k, check k-1
            if (i_cmd.load) begin
                r_k   <= '0;
                r_chk <= 1'b0;
                r_cnt <= '0;
            end else if (i_cmd.probe) begin
                r_chk <= !r_k[2];
                if (!r_k[2]) begin
                    r_k <= r_k + 3'd1;
                end
                if (cand_hit) begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
            // output register
            if (i_cmd.reply) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_opcode;
            r_rnd       <= i_random_word;
            r_mod3      <= mod3(i_random_word);
            r_qx        <= i_query_x;
            r_qy        <= i_query_y;
            r_res_x     <= '0;
            r_res_y     <= '0;
            r_res_valid <= 1'b0;
            r_res_wall  <= 1'b0;
        end
        if (i_cmd.load) begin
            r_cur_x <= s_rdata[GAW-1:AW];
            r_cur_y <= s_rdata[AW-1:0];
        end
        if (i_cmd.probe && !r_k[2]) begin
            r_chk_inb <= pr_inb;
            r_chk_dir <= probe_dir;
        end
        if (i_cmd.probe && cand_hit) begin
            r_dirs[r_cnt[1:0]] <= r_chk_dir;
        end
        if (i_cmd.decide) begin
            r_sel_dir <= r_dirs[pick];
        end
        if (i_cmd.carve_a) begin
            r_res_x     <= rdmc_pkg::COORD_W'(sel_x);
            r_res_y     <= rdmc_pkg::COORD_W'(sel_y);
            r_res_valid <= 1'b1;
        end
        if (i_cmd.rd_issue) begin
            r_rd_inb <= q_inb;
        end
        if (i_cmd.rd_chk) begin
            r_res_wall <= !r_rd_inb || (g_rdata != r_epoch);
        end
        if (i_cmd.reply) begin
            r_out_x    <= r_res_x;
            r_out_y    <= r_res_y;
            r_out_cv   <= r_res_valid;
            r_out_fin  <= (r_depth == '0);
            r_out_wall <= r_res_wall;
        end
    end

    // ---------------------------------------------------------------
    // memories
    // ---------------------------------------------------------------
    rdmc_ram #(
        .WIDTH (TW),
        .DEPTH (GDEP)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    rdmc_ram #(
        .WIDTH (GAW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // ---------------------------------------------------------------
    // status and outputs
    // ---------------------------------------------------------------
    assign o_stat.op          = r_op;
    assign o_stat.clr_last    = (r_clr_addr == '1);
    assign o_stat.epoch_wrap  = (r_epoch == '1);
    assign o_stat.stack_empty = (r_depth == '0);
    assign o_stat.probe_last  = r_k[2];
    assign o_stat.no_cand     = (r_cnt == '0);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_carved_x     = r_out_x;
    assign o_carved_y     = r_out_y;
    assign o_carved_valid = r_out_cv;
    assign o_finished     = r_out_fin;
    assign o_wall_bit     = r_out_wall;

endmodule

// ----- src/random_dfs_maze_carver.sv -----
// Randomized depth-first maze carver, top level.
// Input channel: opcode, random_word, query_x, query_y (valid/ready).
// Output channel: one result per item - carved_x, carved_y, carved_valid,
// finished, wall_bit (valid/ready), held in an output register.
// Config: write enable, index (0 width, 1 height), 7-bit data; written idle.
// Work per item, accept to result register:
//   start: every fifteenth start also reruns the grid
//          clearing pass below, since the per-cell epoch tag wraps.
//   step:  for each stack entry popped: pop, load, four probes pipelined
//          through the grid RAM read port, decide.
//   read:  one grid RAM read.
// Reset: a clearing pass writes all (2**clog2(MAX_DIM))**2 grid entries
// (4096 at MAX_DIM 64), with input ready low; config is taken anyway.
// A new item is taken while the previous result waits in the output
// register; the block holds its next result until the receiver takes it.
// Depends on rdmc_pkg, rdmc_ctrl, rdmc_dpath, rdmc_ram.
module random_dfs_maze_carver #(
    parameter int MAX_DIM     = 64,
    parameter int STACK_DEPTH = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [rdmc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rdmc_pkg::OP_W-1:0]    i_opcode,
    input  logic [rdmc_pkg::RND_W-1:0]   i_random_word,
    input  logic [rdmc_pkg::COORD_W-1:0] i_query_x,
    input  logic [rdmc_pkg::COORD_W-1:0] i_query_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rdmc_pkg::COORD_W-1:0] o_carved_x,
    output logic [rdmc_pkg::COORD_W-1:0] o_carved_y,
    output logic                         o_carved_valid,
    output logic                         o_finished,
    output logic                         o_wall_bit
);

    rdmc_pkg::t_cmd  cmd;
    rdmc_pkg::t_stat stat;

    // sequencer
    rdmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath with grid and stack memories
    rdmc_dpath #(
        .MAX_DIM     (MAX_DIM),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_random_word  (i_random_word),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_carved_x     (o_carved_x),
        .o_carved_y     (o_carved_y),
        .o_carved_valid (o_carved_valid),
        .o_finished     (o_finished),
        .o_wall_bit     (o_wall_bit)
    );

endmodule

// ----- test/tb_random_dfs_maze_carver.sv -----
// Self-checking testbench for random_dfs_maze_carver: start, carve-step and read items
// are predicted by an in-bench depth-first carver and every result is compared per field.
// Depends on rdmc_pkg and the random_dfs_maze_carver RTL.
`timescale 1ns / 1ps

module tb_random_dfs_maze_carver;

    localparam int MAX_DIM     = 64;
    localparam int STACK_DEPTH = 2048;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ITEM_TARGET = 1450;
    // opcode 3 has no function in the block beyond returning a result
    localparam logic [rdmc_pkg::OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [rdmc_pkg::COORD_W-1:0] carved_x;
        logic [rdmc_pkg::COORD_W-1:0] carved_y;
        logic                         carved_valid;
        logic                         finished;
        logic                         wall_bit;
    } t_carve_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic                           i_cfg_idx;
    logic [rdmc_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [rdmc_pkg::OP_W-1:0]      i_opcode;
    logic [rdmc_pkg::RND_W-1:0]     i_random_word;
    logic [rdmc_pkg::COORD_W-1:0]   i_query_x;
    logic [rdmc_pkg::COORD_W-1:0]   i_query_y;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [rdmc_pkg::COORD_W-1:0]   o_carved_x;
    logic [rdmc_pkg::COORD_W-1:0]   o_carved_y;
    logic                           o_carved_valid;
    logic                           o_finished;
    logic                           o_wall_bit;

    // Predicted maze state
    logic [MAX_DIM*MAX_DIM-1:0]     grid_wall;
    logic [11:0]                    visit_stack [STACK_DEPTH];
    int unsigned                    stack_depth;
    logic [rdmc_pkg::CFG_W-1:0]     maze_w_reg;
    logic [rdmc_pkg::CFG_W-1:0]     maze_h_reg;

    t_carve_result carve_results_due [$];
    int            items_sent;
    int            fail_count;
    int            cycle_count;
    int            rx_hold_left;
    bit            tx_idle_on;
    bit            rx_idle_on;

    random_dfs_maze_carver #(
        .MAX_DIM     (MAX_DIM),
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_random_word  (i_random_word),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_carved_x     (o_carved_x),
        .o_carved_y     (o_carved_y),
        .o_carved_valid (o_carved_valid),
        .o_finished     (o_finished),
        .o_wall_bit     (o_wall_bit)
    );

    always #10 i_clk = ~i_clk;

    // Register value as the block uses it: zero acts as one, oversize clamps
    function automatic int effective_extent(input logic [rdmc_pkg::CFG_W-1:0] value);
        if (value == 0) return 1;
        if (value > MAX_DIM) return MAX_DIM;
        return int'(value);
    endfunction

    // Full stack drops the push
    function automatic void push_visit(input int x, input int y);
        if (stack_depth < STACK_DEPTH) begin
            visit_stack[stack_depth] = 12'(x * MAX_DIM + y);
            stack_depth++;
        end
    endfunction

    // Apply one item to the predicted maze and return its result
    function automatic t_carve_result predict_carve(
        input logic [rdmc_pkg::OP_W-1:0]    op,
        input logic [rdmc_pkg::RND_W-1:0]   rnd,
        input logic [rdmc_pkg::COORD_W-1:0] qx,
        input logic [rdmc_pkg::COORD_W-1:0] qy);
        t_carve_result res;
        int            w, h, x, y, nx, ny, n_cand, pick, k;
        int            cand_x [4];
        int            cand_y [4];
        logic [11:0]   top_entry;
        bit            carved;
        res = '0;
        carved = 1'b0;
        w = effective_extent(maze_w_reg);
        h = effective_extent(maze_h_reg);
        case (op)
            rdmc_pkg::OP_START: begin
                grid_wall = '1;
                grid_wall[0] = 1'b0;
                stack_depth = 0;
                push_visit(0, 0);
            end
            rdmc_pkg::OP_STEP: begin
                // backtrack until the top cell has an uncarved neighbor
                while (stack_depth > 0 && !carved) begin
                    stack_depth--;
                    top_entry = visit_stack[stack_depth];
                    x = int'(top_entry) / MAX_DIM;
                    y = int'(top_entry) % MAX_DIM;
                    n_cand = 0;
                    for (k = 0; k < 4; k++) begin
                        nx = x;
                        ny = y;
                        case (rdmc_pkg::t_dir'(k))
                            rdmc_pkg::DIR_YP: ny = y + 2;
                            rdmc_pkg::DIR_XP: nx = x + 2;
                            rdmc_pkg::DIR_YM: ny = y - 2;
                            rdmc_pkg::DIR_XM: nx = x - 2;
                        endcase
                        if (nx >= 0 && ny >= 0 && nx < w && ny < h &&
                            grid_wall[nx * MAX_DIM + ny]) begin
                            cand_x[n_cand] = nx;
                            cand_y[n_cand] = ny;
                            n_cand++;
                        end
                    end
                    if (n_cand > 0) begin
                        pick = int'(rnd) % n_cand;
                        push_visit(x, y);
                        grid_wall[cand_x[pick] * MAX_DIM + cand_y[pick]] = 1'b0;
                        grid_wall[((x + cand_x[pick]) / 2) * MAX_DIM +
                                  (y + cand_y[pick]) / 2] = 1'b0;
                        push_visit(cand_x[pick], cand_y[pick]);
                        res.carved_x = rdmc_pkg::COORD_W'(cand_x[pick]);
                        res.carved_y = rdmc_pkg::COORD_W'(cand_y[pick]);
                        res.carved_valid = 1'b1;
                        carved = 1'b1;
                    end
                end
            end
            rdmc_pkg::OP_READ: begin
                if (int'(qx) < w && int'(qy) < h)
                    res.wall_bit = grid_wall[int'(qx) * MAX_DIM + int'(qy)];
                else
                    res.wall_bit = 1'b1;
            end
            default: ;
        endcase
        res.finished = (stack_depth == 0);
        return res;
    endfunction

    // One input transfer; the expected result is queued on acceptance
    task automatic send_item(input logic [rdmc_pkg::OP_W-1:0]    op,
                             input logic [rdmc_pkg::RND_W-1:0]   rnd,
                             input logic [rdmc_pkg::COORD_W-1:0] qx,
                             input logic [rdmc_pkg::COORD_W-1:0] qy);
        t_carve_result pred;
        @(negedge i_clk);
        while (tx_idle_on && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_random_word <= rnd;
        i_query_x     <= qx;
        i_query_y     <= qy;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_carve(op, rnd, qx, qy);
        carve_results_due = {carve_results_due, pred};
        if (op != OP_NONE) items_sent++;
    endtask

    // Sender goes quiet until every queued result has come back
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (carve_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_extent(input logic idx, input logic [rdmc_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rdmc_pkg::REG_WIDTH) maze_w_reg = value;
        else maze_h_reg = value;
    endtask

    // Extent registers change only with the block idle
    task automatic set_extents(input logic [rdmc_pkg::CFG_W-1:0] w,
                               input logic [rdmc_pkg::CFG_W-1:0] h);
        wait_results_drained();
        write_extent(rdmc_pkg::REG_WIDTH, w);
        write_extent(rdmc_pkg::REG_HEIGHT, h);
    endtask

    function automatic logic [rdmc_pkg::CFG_W-1:0] pick_extent();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) return '0;
        if (roll < 10) return rdmc_pkg::CFG_W'($urandom_range(65, 127));
        if (roll < 16) return rdmc_pkg::CFG_W'($urandom_range(13, 64));
        return rdmc_pkg::CFG_W'($urandom_range(1, 12));
    endfunction

    task automatic check_field(input string field, input logic [rdmc_pkg::COORD_W-1:0] want,
                               input logic [rdmc_pkg::COORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Before any start: empty stack, all walls, unused opcode
    task automatic test_reset_state();
        send_item(rdmc_pkg::OP_STEP, 16'hFFFF, 6'd0, 6'd0);
        send_item(rdmc_pkg::OP_READ, 16'h0000, 6'd0, 6'd0);
        send_item(OP_NONE, 16'hFFFF, 6'd63, 6'd63);
    endtask

    // Extremes of the extent registers, restart and a resize mid-maze
    task automatic test_extent_limits();
        set_extents(7'd0, 7'd0);
        send_item(rdmc_pkg::OP_START, 16'h0000, 6'd0, 6'd0);
        send_item(rdmc_pkg::OP_STEP, 16'h0000, 6'd0, 6'd0);
        send_item(rdmc_pkg::OP_READ, 16'h0000, 6'd0, 6'd0);
        send_item(rdmc_pkg::OP_READ, 16'h0000, 6'd1, 6'd0);
        set_extents(7'd127, 7'd127);
        send_item(rdmc_pkg::OP_START, 16'hFFFF, 6'd63, 6'd63);
        send_item(rdmc_pkg::OP_STEP, 16'h0000, 6'd0, 6'd0);
        send_item(rdmc_pkg::OP_STEP, 16'hFFFF, 6'd63, 6'd63);
        send_item(rdmc_pkg::OP_STEP, 16'hAAAA, 6'h2A, 6'h15);
        send_item(rdmc_pkg::OP_READ, 16'h0000, 6'd63, 6'd63);
        send_item(rdmc_pkg::OP_READ, 16'hFFFF, 6'd0, 6'd2);
        send_item(OP_NONE, 16'h0000, 6'd0, 6'd0);
        // stacked cells stay, later probes see the narrower maze
        set_extents(7'd3, 7'd64);
        send_item(rdmc_pkg::OP_STEP, 16'h5555, 6'd0, 6'd0);
        send_item(rdmc_pkg::OP_STEP, 16'h0001, 6'd0, 6'd0);
        send_item(rdmc_pkg::OP_READ, 16'h0000, 6'd3, 6'd0);
        send_item(rdmc_pkg::OP_READ, 16'h0000, 6'd2, 6'd63);
        send_item(rdmc_pkg::OP_START, 16'h0000, 6'd0, 6'd0);
        send_item(rdmc_pkg::OP_STEP, 16'h8000, 6'd0, 6'd0);
    endtask

    // Deep stack on the full grid
    task automatic test_large_maze();
        int i;
        set_extents(7'd64, 7'd64);
        send_item(rdmc_pkg::OP_START, 16'(($urandom)), 6'd0, 6'd0);
        for (i = 0; i < 260; i++) begin
            if ($urandom_range(9) == 0)
                send_item(rdmc_pkg::OP_READ, 16'($urandom), 6'($urandom), 6'($urandom));
            else
                send_item(rdmc_pkg::OP_STEP, 16'($urandom), 6'($urandom), 6'($urandom));
        end
    endtask

    // Receiver stalls long enough for the block to back up its input
    task automatic test_receiver_hold();
        int i;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_extents(7'd9, 7'd9);
        @(posedge i_clk);
        rx_hold_left = 400;
        send_item(rdmc_pkg::OP_START, 16'h0000, 6'd0, 6'd0);
        for (i = 0; i < 30; i++)
            send_item(i % 7 == 6 ? rdmc_pkg::OP_READ : rdmc_pkg::OP_STEP, 16'($urandom),
                      6'($urandom_range(0, 9)), 6'($urandom_range(0, 9)));
        wait_results_drained();
    endtask

    // Well-formed mazes with random content, plus stray items
    task automatic test_random_mazes();
        int                           maze_idx, ew, eh, n_steps, i, roll;
        logic [rdmc_pkg::CFG_W-1:0]   w, h;
        logic [rdmc_pkg::COORD_W-1:0] qx, qy;
        maze_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            // the first mazes run with no idling at all
            tx_idle_on = (maze_idx >= 8);
            rx_idle_on = (maze_idx >= 8);
            w = pick_extent();
            h = pick_extent();
            set_extents(w, h);
            ew = effective_extent(w);
            eh = effective_extent(h);
            n_steps = ((ew + 1) / 2) * ((eh + 1) / 2) + $urandom_range(0, 2);
            if (n_steps > 60) n_steps = $urandom_range(30, 60);
            send_item(rdmc_pkg::OP_START, 16'($urandom), 6'($urandom), 6'($urandom));
            for (i = 0; i < n_steps; i++) begin
                roll = $urandom_range(99);
                if ($urandom_range(1) == 0) begin
                    qx = 6'($urandom_range(0, ew - 1));
                    qy = 6'($urandom_range(0, eh - 1));
                end else begin
                    qx = 6'($urandom);
                    qy = 6'($urandom);
                end
                if (roll < 84) begin
                    send_item(rdmc_pkg::OP_STEP, 16'($urandom), qx, qy);
                end else if (roll < 92) begin
                    send_item(rdmc_pkg::OP_READ, 16'($urandom), qx, qy);
                end else if (roll < 96) begin
                    send_item(OP_NONE, 16'($urandom), qx, qy);
                end else if (roll < 98) begin
                    send_item(rdmc_pkg::OP_START, 16'($urandom), qx, qy);
                end else begin
                    w = pick_extent();
                    h = pick_extent();
                    set_extents(w, h);
                    ew = effective_extent(w);
                    eh = effective_extent(h);
                end
            end
            for (i = 0; i < 3; i++)
                send_item(rdmc_pkg::OP_READ, 16'($urandom), 6'($urandom_range(0, ew)),
                          6'($urandom_range(0, eh)));
            maze_idx++;
        end
    endtask

    // Receiver: random idling, or a counted hold-off
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(rx_idle_on && $urandom_range(99) < 9);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_carve_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (carve_results_due.size() == 0) begin
                $error("result transfer with no item outstanding");
                fail_count++;
            end else begin
                want = carve_results_due.pop_front();
                check_field("carved_x", want.carved_x, o_carved_x);
                check_field("carved_y", want.carved_y, o_carved_y);
                check_field("carved_valid", rdmc_pkg::COORD_W'(want.carved_valid),
                            rdmc_pkg::COORD_W'(o_carved_valid));
                check_field("finished", rdmc_pkg::COORD_W'(want.finished),
                            rdmc_pkg::COORD_W'(o_finished));
                check_field("wall_bit", rdmc_pkg::COORD_W'(want.wall_bit),
                            rdmc_pkg::COORD_W'(o_wall_bit));
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = rdmc_pkg::REG_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_opcode      = rdmc_pkg::OP_START;
        i_random_word = '0;
        i_query_x     = '0;
        i_query_y     = '0;
        i_out_ready   = 1'b0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        rx_hold_left  = 0;
        fail_count    = 0;
        cycle_count   = 0;
        items_sent    = 0;
        grid_wall     = '1;
        stack_depth   = 0;
        maze_w_reg    = rdmc_pkg::EXTENT_RESET;
        maze_h_reg    = rdmc_pkg::EXTENT_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_extent_limits();
        test_large_maze();
        test_receiver_hold();
        test_random_mazes();

        // let any stray result show up before the verdict
        wait_results_drained();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
